// ===== rtl/pbb_pkg.sv =====
// ----------------------------------------------------------------------------
// pbb_pkg
// Shared constants and types for the pixel block binning datapath.
// ----------------------------------------------------------------------------
package pbb_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W  = 16;
  localparam int DIM_W  = 13;
  localparam int BIN_W  = 2;
  localparam int SUM_W  = 22;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int CIDX_W = 2;

  // register indexes of the configuration port
  localparam logic [CIDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CIDX_W-1:0] REG_BIN    = 2'd2;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd600;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd400;
  localparam logic [BIN_W-1:0] BIN_RST    = 2'd1;

  localparam int RES_DEPTH = 3;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             last;
  } pbb_res_t;

endpackage

// ===== rtl/pbb_ram.sv =====
// ----------------------------------------------------------------------------
// pbb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/pixel_block_binning.sv =====
// ----------------------------------------------------------------------------
// pixel_block_binning
// Streaming bin-by-bin block averaging of 16-bit grey pixels.
// ----------------------------------------------------------------------------
// a binned result passes the stage 1 registers and result queue to out_valid
// throughput: 1 pixel per cycle unless in_stall, set by one read and one write
//   port of the column sum RAM (read at accept, add and write back the next cycle)
// a three-entry result queue decouples the output stall from the input side
// reset: counters, running sum, config and queue are cleared synchronously;
//   the column sum RAM is not cleared, its entries are written before use
module pixel_block_binning (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [pbb_pkg::PIX_W-1:0]    in_pixel_value,
  input  logic                         in_frame_start,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [pbb_pkg::PIX_W-1:0]    out_binned_value,
  output logic                         out_frame_last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [pbb_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [pbb_pkg::DIM_W-1:0]    cfg_data
);
  import pbb_pkg::*;

  // configuration
  logic [DIM_W-1:0] width_r, height_r;
  logic [BIN_W-1:0] bin_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      bin_r    <= BIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        REG_BIN:    bin_r    <= cfg_data[BIN_W-1:0];
        default:    ;
      endcase
    end
  end

  // position and running sum
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [SUM_W-1:0] brs_r, brs_nxt;

  logic [COL_W:0]   w_eff, used_w, col_inc;
  logic [ROW_W:0]   h_eff, used_h, row_inc;
  logic [COL_W-1:0] colc, idx;
  logic [ROW_W-1:0] rowc;
  logic [2:0]       mask;
  logic             in_blk, first_col, last_col, first_row, last_row, is_last;
  logic             acc;

  // stage 1 registers
  logic             s1_v_r;
  logic [COL_W-1:0] s1_idx_r;
  logic [SUM_W-1:0] s1_brs_r;
  logic             s1_first_row_r, s1_emit_r, s1_last_r;
  logic [BIN_W-1:0] s1_bin_r;

  // result queue
  pbb_res_t         res_q [RES_DEPTH];
  logic [1:0]       wr_ptr_r, rd_ptr_r;
  logic [1:0]       cnt_r;
  logic             push, pop;
  logic [2:0]       pending;

  assign pending  = {1'b0, cnt_r} + {2'b00, s1_v_r && s1_emit_r};
  assign in_stall = (pending >= 3'(RES_DEPTH));
  assign acc      = in_valid && !in_stall;

  always_comb begin
    if (width_r == '0) begin
      w_eff = (COL_W+1)'(1);
    end else if (int'(width_r) > MAX_WIDTH) begin
      w_eff = (COL_W+1)'(MAX_WIDTH);
    end else begin
      w_eff = (COL_W+1)'(width_r);
    end
    if (height_r == '0) begin
      h_eff = (ROW_W+1)'(1);
    end else if (int'(height_r) > MAX_HEIGHT) begin
      h_eff = (ROW_W+1)'(MAX_HEIGHT);
    end else begin
      h_eff = (ROW_W+1)'(height_r);
    end

    used_w = (w_eff >> bin_r) << bin_r;
    used_h = (h_eff >> bin_r) << bin_r;
    mask   = 3'((4'd1 << bin_r) - 4'd1);

    colc = in_frame_start ? '0 : col_r;
    rowc = in_frame_start ? '0 : row_r;
    if ({1'b0, colc} >= w_eff) colc = '0;
    if ({1'b0, rowc} >= h_eff) rowc = '0;

    in_blk    = ({1'b0, colc} < used_w) && ({1'b0, rowc} < used_h);
    first_col = (colc[2:0] & mask) == 3'd0;
    last_col  = (colc[2:0] & mask) == mask;
    first_row = (rowc[2:0] & mask) == 3'd0;
    last_row  = (rowc[2:0] & mask) == mask;
    is_last   = ({1'b0, colc} == used_w - 1'b1) && ({1'b0, rowc} == used_h - 1'b1);
    idx       = colc >> bin_r;

    brs_nxt = brs_r;
    if (in_blk) begin
      brs_nxt = first_col ? SUM_W'(in_pixel_value) : brs_r + SUM_W'(in_pixel_value);
    end

    col_inc = {1'b0, colc} + 1'b1;
    row_inc = {1'b0, rowc} + 1'b1;
    if (col_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_nxt = col_inc[COL_W-1:0];
      row_nxt = rowc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      brs_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= acc && in_blk && last_col;
      if (acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        brs_r <= brs_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_idx_r       <= idx;
      s1_brs_r       <= brs_nxt;
      s1_first_row_r <= first_row;
      s1_emit_r      <= last_row;
      s1_last_r      <= is_last;
      s1_bin_r       <= bin_r;
    end
  end

  // column sum RAM: read at accept, add and write back in stage 1
  logic [SUM_W-1:0] ram_rdata, total;
  logic [2:0]       shamt;
  logic             rd_need;

  assign rd_need = acc && in_blk && last_col && !first_row;
  assign total   = s1_first_row_r ? s1_brs_r : ram_rdata + s1_brs_r;
  assign shamt   = {s1_bin_r, 1'b0};

  pbb_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_WIDTH)
  ) u_col_ram (
    .clk   (clk),
    .we    (s1_v_r),
    .waddr (s1_idx_r),
    .wdata (total),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  // result queue
  assign push = s1_v_r && s1_emit_r;
  assign pop  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == 2'(RES_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == 2'(RES_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res_q[wr_ptr_r].value <= PIX_W'(total >> shamt);
      res_q[wr_ptr_r].last  <= s1_last_r;
    end
  end

  assign out_valid        = (cnt_r != '0);
  assign out_binned_value = res_q[rd_ptr_r].value;
  assign out_frame_last   = res_q[rd_ptr_r].last;

`ifndef SYNTHESIS
  // queue never takes a beat it has no room for
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !pop && cnt_r == 2'(RES_DEPTH)))
    else $error("result queue overflow");

  // a needed read never collides with the write-back of the same entry
  a_no_rmw_hazard: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_need && s1_v_r) |-> (idx != s1_idx_r))
    else $error("column sum read/write overlap");

  // frame start takes its pixel as the top-left corner, so the next position is at most one step on
  a_frame_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_frame_start) |=> (col_r <= COL_W'(1) && row_r <= ROW_W'(1)))
    else $error("frame start did not resync position");
`endif

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for pixel_block_binning. A short table of directed
// pixels and register writes runs first, then random frames under many
// width, height and bin settings. Each result is checked against the table's
// value or a bit-true predictor while both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import pbb_pkg::*;

  localparam logic [CIDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1350;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 4;
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum logic [1:0] {ROW_CFG, ROW_PIX, ROW_CHK} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [CIDX_W-1:0] idx;
    logic [DIM_W-1:0]  data;
    logic [PIX_W-1:0]  pix;
    logic              fs;
    pbb_res_t          res;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [PIX_W-1:0]  in_pixel_value = '0;
  logic              in_frame_start = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [PIX_W-1:0]  out_binned_value;
  logic              out_frame_last;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]  cfg_data = '0;

  // predictor state and register mirror
  logic [DIM_W-1:0] reg_width  = WIDTH_RST;
  logic [DIM_W-1:0] reg_height = HEIGHT_RST;
  logic [BIN_W-1:0] reg_bin    = BIN_RST;
  logic [SUM_W-1:0] col_sums [MAX_WIDTH];
  logic [SUM_W-1:0] run_sum = '0;
  logic [COL_W-1:0] col_pos = '0;
  logic [ROW_W-1:0] row_pos = '0;

  pbb_res_t  binned_q [$];
  stim_row_t dir_rows [$];

  int errors = 0;
  int cycles = 0;
  int burst_left = 0;
  int hold_left = 0;
  int run_left = 0;
  bit hold_req = 1'b0;

  pixel_block_binning dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel_value   (in_pixel_value),
    .in_frame_start   (in_frame_start),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_binned_value (out_binned_value),
    .out_frame_last   (out_frame_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, want);
    errors++;
  endtask

  // block average of one pixel beat, returns 1 when a binned pixel comes out
  function automatic bit bin_predict(input logic [PIX_W-1:0] pix, input logic fs,
                                     output pbb_res_t res);
    int unsigned w, h, mask, used_w, used_h, c, r, idx;
    logic [SUM_W-1:0] total, shifted;
    bit hit;
    hit = 1'b0;
    res = '0;
    w = 32'(reg_width);
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = 32'(reg_height);
    if (h == 0) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    mask = (1 << reg_bin) - 1;
    used_w = (w >> reg_bin) << reg_bin;
    used_h = (h >> reg_bin) << reg_bin;
    if (fs) begin
      col_pos = '0;
      row_pos = '0;
    end
    if (col_pos >= w) col_pos = '0;
    if (row_pos >= h) row_pos = '0;
    c = 32'(col_pos);
    r = 32'(row_pos);
    if (c < used_w && r < used_h) begin
      idx = (c >> reg_bin) & (MAX_WIDTH - 1);
      if ((c & mask) == 0) run_sum = SUM_W'(pix);
      else run_sum = run_sum + SUM_W'(pix);
      if ((c & mask) == mask) begin
        if ((r & mask) == 0) total = run_sum;
        else total = col_sums[idx] + run_sum;
        col_sums[idx] = total;
        if ((r & mask) == mask) begin
          shifted = total >> (2 * reg_bin);
          res.value = shifted[PIX_W-1:0];
          res.last = (c == used_w - 1) && (r == used_h - 1);
          hit = 1'b1;
        end
      end
    end
    if (c + 1 >= w) begin
      col_pos = '0;
      if (r + 1 >= h) row_pos = '0;
      else row_pos = ROW_W'(r + 1);
    end else begin
      col_pos = COL_W'(c + 1);
    end
    return hit;
  endfunction

  task automatic add_row(input row_kind_t kind, input logic [CIDX_W-1:0] idx,
                         input logic [DIM_W-1:0] data, input logic [PIX_W-1:0] pix,
                         input logic fs, input logic [PIX_W-1:0] value,
                         input logic last);
    stim_row_t row;
    row.kind = kind;
    row.idx = idx;
    row.data = data;
    row.pix = pix;
    row.fs = fs;
    row.res.value = value;
    row.res.last = last;
    dir_rows.push_back(row);
  endtask

  // sender works in bursts with random gaps between them
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs,
                            input bit typed, input pbb_res_t typed_res);
    pbb_res_t res;
    bit hit;
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(40, 80);
      else burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) @(negedge clk) in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_pixel_value <= pix;
    in_frame_start <= fs;
    do @(posedge clk); while (in_stall);
    burst_left--;
    hit = bin_predict(pix, fs, res);
    if (typed) binned_q.push_back(typed_res);
    else if (hit) binned_q.push_back(res);
  endtask

  // stop sending and wait until every binned pixel has come out
  task automatic drain_results();
    @(negedge clk) in_valid <= 1'b0;
    while (binned_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_WIDTH:  reg_width = data;
      REG_HEIGHT: reg_height = data;
      REG_BIN:    reg_bin = data[BIN_W-1:0];
      default: ;
    endcase
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  function automatic int pick_dim(input int b);
    int d;
    case ($urandom_range(0, 11))
      0: d = 0;
      1: d = 8191;
      2: d = MAX_WIDTH;
      3: d = $urandom_range(1, 8191);
      4: d = $urandom_range(1, 1 << b);
      default: begin
        d = (1 << b) * $urandom_range(1, (b == 3) ? 2 : 4);
        if ($urandom_range(0, 2) == 0) d = d + $urandom_range(0, (1 << b) - 1);
      end
    endcase
    return d;
  endfunction

  // receiver stall pattern, with one long hold on request
  always @(negedge clk) begin : stall_pattern
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (run_left > 0) begin
      run_left--;
    end else if ($urandom_range(0, 9) == 0) begin
      run_left = $urandom_range(30, 60);
      out_stall <= 1'b0;
    end else begin
      run_left = $urandom_range(0, 4);
      out_stall <= ($urandom_range(0, 2) == 0);
    end
  end

  always @(posedge clk) begin : check_results
    pbb_res_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (binned_q.size() == 0) begin
        report_mismatch("result with none expected", 32'(out_binned_value), 0);
      end else begin
        want = binned_q.pop_front();
        if (out_binned_value !== want.value)
          report_mismatch("binned_value", 32'(out_binned_value), 32'(want.value));
        if (out_frame_last !== want.last)
          report_mismatch("frame_last", 32'(out_frame_last), 32'(want.last));
      end
    end
  end

  initial begin : main_seq
    stim_row_t row;
    pbb_res_t none;
    int n, items, phase, b, w, h;
    logic fs;
    logic [PIX_W-1:0] pix;
    none = '0;
    foreach (col_sums[i]) col_sums[i] = '0;

    // reset settings, then a single 2x2 block per frame
    add_row(ROW_PIX, '0, '0, 16'hFFFF, 1'b1, '0, 1'b0);
    add_row(ROW_PIX, '0, '0, 16'h0000, 1'b0, '0, 1'b0);
    add_row(ROW_CFG, REG_WIDTH, 13'd2, '0, 1'b0, '0, 1'b0);
    add_row(ROW_CFG, REG_HEIGHT, 13'd2, '0, 1'b0, '0, 1'b0);
    add_row(ROW_CFG, REG_BIN, 13'd1, '0, 1'b0, '0, 1'b0);
    add_row(ROW_PIX, '0, '0, 16'hFFFF, 1'b1, '0, 1'b0);
    add_row(ROW_PIX, '0, '0, 16'hFFFF, 1'b0, '0, 1'b0);
    add_row(ROW_PIX, '0, '0, 16'hFFFF, 1'b0, '0, 1'b0);
    add_row(ROW_CHK, '0, '0, 16'hFFFF, 1'b0, 16'hFFFF, 1'b1);
    // next frame starts by wrapping, no frame start
    add_row(ROW_PIX, '0, '0, 16'h0000, 1'b0, '0, 1'b0);
    add_row(ROW_PIX, '0, '0, 16'h0000, 1'b0, '0, 1'b0);
    add_row(ROW_PIX, '0, '0, 16'h0000, 1'b0, '0, 1'b0);
    add_row(ROW_CHK, '0, '0, 16'h0000, 1'b0, 16'h0000, 1'b1);
    // frame start after one pixel, average truncates 11/4 to 2
    add_row(ROW_PIX, '0, '0, 16'h0007, 1'b0, '0, 1'b0);
    add_row(ROW_PIX, '0, '0, 16'h0001, 1'b1, '0, 1'b0);
    add_row(ROW_PIX, '0, '0, 16'h0002, 1'b0, '0, 1'b0);
    add_row(ROW_PIX, '0, '0, 16'h0003, 1'b0, '0, 1'b0);
    add_row(ROW_CHK, '0, '0, 16'h0005, 1'b0, 16'h0002, 1'b1);
    // bin factor of one passes pixels through
    add_row(ROW_CFG, REG_BIN, 13'd0, '0, 1'b0, '0, 1'b0);
    add_row(ROW_CFG, REG_WIDTH, 13'd3, '0, 1'b0, '0, 1'b0);
    add_row(ROW_CHK, '0, '0, 16'h1234, 1'b1, 16'h1234, 1'b0);
    add_row(ROW_CHK, '0, '0, 16'hFFFF, 1'b0, 16'hFFFF, 1'b0);
    // zero width and height act as a 1x1 frame
    add_row(ROW_CFG, REG_WIDTH, 13'd0, '0, 1'b0, '0, 1'b0);
    add_row(ROW_CFG, REG_HEIGHT, 13'd0, '0, 1'b0, '0, 1'b0);
    add_row(ROW_CHK, '0, '0, 16'hABCD, 1'b1, 16'hABCD, 1'b1);
    add_row(ROW_CHK, '0, '0, 16'h0000, 1'b0, 16'h0000, 1'b1);
    // width below the bin factor, saturated height
    add_row(ROW_CFG, REG_BIN, 13'd3, '0, 1'b0, '0, 1'b0);
    add_row(ROW_CFG, REG_WIDTH, 13'd5, '0, 1'b0, '0, 1'b0);
    add_row(ROW_CFG, REG_HEIGHT, 13'h1FFF, '0, 1'b0, '0, 1'b0);
    add_row(ROW_PIX, '0, '0, 16'h5555, 1'b1, '0, 1'b0);
    add_row(ROW_PIX, '0, '0, 16'hAAAA, 1'b0, '0, 1'b0);
    // saturated width
    add_row(ROW_CFG, REG_WIDTH, 13'h1FFF, '0, 1'b0, '0, 1'b0);
    add_row(ROW_CFG, REG_BIN, 13'd2, '0, 1'b0, '0, 1'b0);
    add_row(ROW_PIX, '0, '0, 16'hFFFF, 1'b1, '0, 1'b0);
    add_row(ROW_PIX, '0, '0, 16'h0001, 1'b0, '0, 1'b0);
    add_row(ROW_CFG, REG_UNUSED, 13'h1FFF, '0, 1'b0, '0, 1'b0);

    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_CFG) begin
        drain_results();
        write_reg(row.idx, row.data);
      end else begin
        send_pixel(row.pix, row.fs, row.kind == ROW_CHK, row.res);
      end
    end

    items = 0;
    phase = 0;
    while (items < RANDOM_ITEMS) begin
      drain_results();
      b = $urandom_range(0, 3);
      w = pick_dim(b);
      h = pick_dim(b);
      // pass-through phase that fills the block during a long output hold
      if (phase == 2) begin
        b = 0;
        w = 16;
        h = 8;
      end
      write_reg(REG_WIDTH, DIM_W'(w));
      write_reg(REG_HEIGHT, DIM_W'(h));
      write_reg(REG_BIN, DIM_W'(b));
      if (w * h > 2048 && b != 0) n = $urandom_range(16, 48);
      else n = $urandom_range(60, 160);
      if (phase == 2) hold_req = 1'b1;
      for (int k = 0; k < n; k++) begin
        // first beat after a register change always starts a frame
        if (k == 0) fs = 1'b1;
        else if (col_pos == 0 && row_pos == 0) fs = ($urandom_range(0, 9) < 7);
        else fs = ($urandom_range(0, 39) == 0);
        case ($urandom_range(0, 7))
          0: pix = '0;
          1: pix = '1;
          default: pix = PIX_W'($urandom);
        endcase
        send_pixel(pix, fs, 1'b0, none);
      end
      items += n;
      phase++;
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
